// ===== design/dmws_pkg.sv =====
// Shared constants, codes and types for the difference multiplicity window step.
package dmws_pkg;

  localparam int MASK_W     = 63;  // input and extended mask width
  localparam int SHIFT_W    = 62;  // shifted mask width
  localparam int CFG_W      = 6;   // configuration field width
  localparam int CNT_W      = 6;   // pair count width, a count never exceeds 62
  localparam int GROUP_W    = 8;   // bits per partial popcount group
  localparam int NUM_GROUPS = (MASK_W + GROUP_W - 1) / GROUP_W;
  localparam int GCNT_W     = 4;   // partial count width, holds 0..8

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [CFG_W-1:0] WIDTH_RESET   = 6'd30;
  localparam logic [CFG_W-1:0] REPEATS_RESET = 6'd2;
  localparam logic [CFG_W-1:0] MIN_WIDTH     = 6'd3;

  typedef enum logic [0:0] {
    REG_WIDTH   = 1'b0,
    REG_REPEATS = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [SHIFT_W-1:0] shifted_mask;
    logic [MASK_W-1:0]  extended_mask;
  } item_t;

endpackage

// ===== design/dmws_mask_if.sv =====
// Input channel: one window occupancy mask per item.
interface dmws_mask_if;
  logic                         valid;
  logic                         ready;
  logic [dmws_pkg::MASK_W-1:0]  window_mask;

  modport source (output valid, output window_mask, input ready);
  modport sink   (input valid, input window_mask, output ready);
endinterface

// ===== design/dmws_result_if.sv =====
// Output channel: both successor windows and the extension verdict per item.
interface dmws_result_if;
  logic                         valid;
  logic                         ready;
  logic [dmws_pkg::SHIFT_W-1:0] shifted_mask;
  logic [dmws_pkg::MASK_W-1:0]  extended_mask;
  logic                         extend_ok;

  modport source (output valid, output shifted_mask, output extended_mask,
                  output extend_ok, input ready);
  modport sink   (input valid, input shifted_mask, input extended_mask,
                  input extend_ok, output ready);
endinterface

// ===== design/dmws_diff_check.sv =====
// Three-stage pipelined pairwise difference count check on the extended mask.
module dmws_diff_check #(
  parameter int MAX_WIDTH = 63
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  dmws_pkg::item_t             in_item,
  input  logic [dmws_pkg::CFG_W-1:0]  limit,
  dmws_result_if.source               result
);

  localparam int ND = MAX_WIDTH - 1;  // differences 1 .. MAX_WIDTH-1

  // stage B: partial popcounts of ext & (ext >> d) per difference
  logic                        b_valid;
  dmws_pkg::item_t             b_item;
  logic [dmws_pkg::GCNT_W-1:0] b_cnt      [ND][dmws_pkg::NUM_GROUPS];
  logic [dmws_pkg::GCNT_W-1:0] b_cnt_next [ND][dmws_pkg::NUM_GROUPS];

  // stage C: per-difference over-limit flags
  logic                        c_valid;
  dmws_pkg::item_t             c_item;
  logic [ND-1:0]               c_over;
  logic [ND-1:0]               c_over_next;

  // stage D: output register
  logic                        d_valid;
  dmws_pkg::item_t             d_item;
  logic                        d_ok;

  logic d_adv, c_adv, b_adv;

  assign d_adv    = !d_valid || result.ready;
  assign c_adv    = !c_valid || d_adv;
  assign b_adv    = !b_valid || c_adv;
  assign in_ready = b_adv;

  always_comb begin
    logic [dmws_pkg::MASK_W-1:0] pairs;
    for (int d = 0; d < ND; d++) begin
      pairs = in_item.extended_mask & (in_item.extended_mask >> (d + 1));
      for (int g = 0; g < dmws_pkg::NUM_GROUPS; g++) begin
        b_cnt_next[d][g] = '0;
        for (int k = 0; k < dmws_pkg::GROUP_W; k++) begin
          if (g * dmws_pkg::GROUP_W + k < dmws_pkg::MASK_W) begin
            b_cnt_next[d][g] = b_cnt_next[d][g]
                + {{(dmws_pkg::GCNT_W-1){1'b0}}, pairs[g * dmws_pkg::GROUP_W + k]};
          end
        end
      end
    end
  end

  always_comb begin
    logic [dmws_pkg::CNT_W-1:0] sum;
    for (int d = 0; d < ND; d++) begin
      sum = '0;
      for (int g = 0; g < dmws_pkg::NUM_GROUPS; g++) begin
        sum = sum + {{(dmws_pkg::CNT_W-dmws_pkg::GCNT_W){1'b0}}, b_cnt[d][g]};
      end
      c_over_next[d] = sum > limit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
    end else begin
      if (b_adv) b_valid <= in_valid;
      if (c_adv) c_valid <= b_valid;
      if (d_adv) d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv && in_valid) begin
      b_item <= in_item;
      b_cnt  <= b_cnt_next;
    end
    if (c_adv && b_valid) begin
      c_item <= b_item;
      c_over <= c_over_next;
    end
    if (d_adv && c_valid) begin
      d_item <= c_item;
      d_ok   <= ~|c_over;
    end
  end

  assign result.valid         = d_valid;
  assign result.shifted_mask  = d_item.shifted_mask;
  assign result.extended_mask = d_item.extended_mask;
  assign result.extend_ok     = d_ok;

endmodule

// ===== design/difference_multiplicity_window_step.sv =====
// Top level: config registers, window trim and shift stage, difference check pipeline.
//
// Each accepted window mask yields one result: the mask trimmed to
// window_width positions and moved down one (shifted_mask), the same with
// the top position window_width-1 set (extended_mask), and extend_ok, which
// is 1 when no pairwise difference d among the extended window's set bits
// occurs more than max_repeats times. One item is accepted every cycle
// while the pipe is not held by a stall. Each item passes four register
// stages (trim/shift stage, partial popcount stage, count sum and compare
// stage, verdict reduce stage, which is the output register). The popcount of
// ext & (ext >> d) for every d is split into 8-bit groups in one stage and
// summed in the next, which sets the latency. Valid bits travel with the
// data and each stage holds when the one after it is full, so a stall at
// the output backs up the pipe without losing or repeating items.
// window_width below 3 acts as 3 and above MAX_WIDTH as MAX_WIDTH.
// Registers sit on an APB port at byte addresses 0 (window_width) and
// 4 (max_repeats); change them only while the pipe is empty.
module difference_multiplicity_window_step #(
  parameter int MAX_WIDTH = 63
) (
  input  logic                             clk,
  input  logic                             rst,
  dmws_mask_if.sink                        window,
  dmws_result_if.source                    result,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [dmws_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [dmws_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [dmws_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);

  // configuration registers
  logic [dmws_pkg::CFG_W-1:0] window_width;
  logic [dmws_pkg::CFG_W-1:0] max_repeats;
  dmws_pkg::reg_index_t       reg_sel;
  logic                       cfg_write;

  assign pready    = 1'b1;
  assign reg_sel   = dmws_pkg::reg_index_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_width <= dmws_pkg::WIDTH_RESET;
      max_repeats  <= dmws_pkg::REPEATS_RESET;
    end else if (cfg_write) begin
      case (reg_sel)
        dmws_pkg::REG_WIDTH:   window_width <= pwdata[dmws_pkg::CFG_W-1:0];
        dmws_pkg::REG_REPEATS: max_repeats  <= pwdata[dmws_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      dmws_pkg::REG_WIDTH:
        prdata = {{(dmws_pkg::APB_DATA_W-dmws_pkg::CFG_W){1'b0}}, window_width};
      dmws_pkg::REG_REPEATS:
        prdata = {{(dmws_pkg::APB_DATA_W-dmws_pkg::CFG_W){1'b0}}, max_repeats};
      default:
        prdata = '0;
    endcase
  end

  // effective width, clamped to 3 .. MAX_WIDTH
  logic [dmws_pkg::CFG_W-1:0] width_eff;

  always_comb begin
    width_eff = window_width;
    if (width_eff < dmws_pkg::MIN_WIDTH) width_eff = dmws_pkg::MIN_WIDTH;
    if (width_eff > dmws_pkg::CFG_W'(MAX_WIDTH)) width_eff = dmws_pkg::CFG_W'(MAX_WIDTH);
  end

  // stage A: trim to the window, shift down, set the top position
  logic                        a_valid;
  dmws_pkg::item_t             a_item;
  dmws_pkg::item_t             a_item_next;
  logic                        a_adv;
  logic                        chk_ready;
  logic [dmws_pkg::MASK_W-1:0] trimmed;
  logic [dmws_pkg::MASK_W-1:0] shifted;
  logic [dmws_pkg::MASK_W-1:0] extended;

  always_comb begin
    for (int i = 0; i < dmws_pkg::MASK_W; i++) begin
      trimmed[i] = window.window_mask[i] && (dmws_pkg::CFG_W'(i) < width_eff);
    end
    shifted  = trimmed >> 1;
    extended = shifted;
    for (int i = 0; i < dmws_pkg::MASK_W; i++) begin
      if (dmws_pkg::CFG_W'(i + 1) == width_eff) extended[i] = 1'b1;
    end
    a_item_next.shifted_mask  = shifted[dmws_pkg::SHIFT_W-1:0];
    a_item_next.extended_mask = extended;
  end

  assign a_adv        = !a_valid || chk_ready;
  assign window.ready = a_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_adv) begin
      a_valid <= window.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv && window.valid) begin
      a_item <= a_item_next;
    end
  end

  // stages B, C, D: difference counts, limit compare, verdict and output
  dmws_diff_check #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_check (
    .clk      (clk),
    .rst      (rst),
    .in_valid (a_valid),
    .in_ready (chk_ready),
    .in_item  (a_item),
    .limit    (max_repeats),
    .result   (result)
  );

endmodule

// ===== sim/testbench.sv =====
// Self-checking bench for the difference multiplicity window step.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES  = 8;     // pipe is four deep, leave margin
  localparam int MAX_GAP       = 13;
  localparam int NUM_PHASES    = 12;
  localparam int PHASE_ITEMS   = 100;
  localparam int NUM_DIRECTED  = 29;

  // One expected (or observed) result item.
  typedef struct packed {
    logic [dmws_pkg::SHIFT_W-1:0] shifted_mask;
    logic [dmws_pkg::MASK_W-1:0]  extended_mask;
    logic                         extend_ok;
  } window_result_t;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

  // Directed row: either a register write or a mask item. For items with
  // typed = 1 the result is given here; otherwise the predictor supplies it.
  typedef struct packed {
    row_kind_t                   kind;
    dmws_pkg::reg_index_t        reg_sel;
    logic [dmws_pkg::MASK_W-1:0] value;
    bit                          typed;
    window_result_t              want;
  } stim_row_t;

  localparam logic [dmws_pkg::MASK_W-1:0]  ALL_ONES = {dmws_pkg::MASK_W{1'b1}};
  localparam logic [dmws_pkg::SHIFT_W-1:0] SH_NONE  = '0;

  // Directed table. The first block runs with the reset settings (30, 2).
  stim_row_t directed_rows [NUM_DIRECTED] = '{
    // empty window: only the new top position is set
    '{ROW_ITEM, dmws_pkg::REG_WIDTH,   63'h0, 1'b1, '{SH_NONE, 63'h2000_0000, 1'b1}},
    // full mask: trimmed to 30, adjacent pairs far above the limit
    '{ROW_ITEM, dmws_pkg::REG_WIDTH,   ALL_ONES, 1'b1,
      '{62'h1FFF_FFFF, 63'h3FFF_FFFF, 1'b0}},
    // only bits beyond the window: all ignored
    '{ROW_ITEM, dmws_pkg::REG_WIDTH,   63'h7FFF_FFFF_C000_0000, 1'b1,
      '{SH_NONE, 63'h2000_0000, 1'b1}},
    // bit 0 falls out on the shift
    '{ROW_ITEM, dmws_pkg::REG_WIDTH,   63'h1, 1'b1, '{SH_NONE, 63'h2000_0000, 1'b1}},
    '{ROW_ITEM, dmws_pkg::REG_WIDTH,   63'h1234_5678_9ABC_DEF0, 1'b0, '0},
    '{ROW_ITEM, dmws_pkg::REG_WIDTH,   63'h2AAA_AAAA, 1'b0, '0},
    '{ROW_ITEM, dmws_pkg::REG_WIDTH,   63'h2000_0009, 1'b0, '0},
    // narrowest window
    '{ROW_CFG,  dmws_pkg::REG_WIDTH,   63'd3, 1'b0, '0},
    '{ROW_ITEM, dmws_pkg::REG_WIDTH,   ALL_ONES, 1'b1, '{62'h3, 63'h7, 1'b1}},
    '{ROW_CFG,  dmws_pkg::REG_REPEATS, 63'd1, 1'b0, '0},
    '{ROW_ITEM, dmws_pkg::REG_WIDTH,   ALL_ONES, 1'b1, '{62'h3, 63'h7, 1'b0}},
    // widths below the minimum act as 3
    '{ROW_CFG,  dmws_pkg::REG_WIDTH,   63'd0, 1'b0, '0},
    '{ROW_ITEM, dmws_pkg::REG_WIDTH,   ALL_ONES, 1'b1, '{62'h3, 63'h7, 1'b0}},
    '{ROW_CFG,  dmws_pkg::REG_WIDTH,   63'd2, 1'b0, '0},
    '{ROW_ITEM, dmws_pkg::REG_WIDTH,   63'h5, 1'b1, '{62'h2, 63'h6, 1'b1}},
    '{ROW_CFG,  dmws_pkg::REG_WIDTH,   63'd1, 1'b0, '0},
    '{ROW_ITEM, dmws_pkg::REG_WIDTH,   63'h4, 1'b1, '{62'h2, 63'h6, 1'b1}},
    // widest window, limits at both ends
    '{ROW_CFG,  dmws_pkg::REG_WIDTH,   63'd63, 1'b0, '0},
    '{ROW_CFG,  dmws_pkg::REG_REPEATS, 63'd63, 1'b0, '0},
    '{ROW_ITEM, dmws_pkg::REG_WIDTH,   ALL_ONES, 1'b1,
      '{62'h3FFF_FFFF_FFFF_FFFF, ALL_ONES, 1'b1}},
    '{ROW_CFG,  dmws_pkg::REG_REPEATS, 63'd61, 1'b0, '0},
    '{ROW_ITEM, dmws_pkg::REG_WIDTH,   ALL_ONES, 1'b1,
      '{62'h3FFF_FFFF_FFFF_FFFF, ALL_ONES, 1'b0}},
    // zero repeats: accepted only with an empty shifted window
    '{ROW_CFG,  dmws_pkg::REG_REPEATS, 63'd0, 1'b0, '0},
    '{ROW_ITEM, dmws_pkg::REG_WIDTH,   63'h0, 1'b1,
      '{SH_NONE, 63'h4000_0000_0000_0000, 1'b1}},
    '{ROW_ITEM, dmws_pkg::REG_WIDTH,   63'h2, 1'b1,
      '{62'h1, 63'h4000_0000_0000_0001, 1'b0}},
    '{ROW_ITEM, dmws_pkg::REG_WIDTH,   63'h1, 1'b1,
      '{SH_NONE, 63'h4000_0000_0000_0000, 1'b1}},
    '{ROW_ITEM, dmws_pkg::REG_WIDTH,   63'h7FFF_FFFF_FFFF_FFFE, 1'b0, '0},
    '{ROW_CFG,  dmws_pkg::REG_WIDTH,   63'd62, 1'b0, '0},
    '{ROW_ITEM, dmws_pkg::REG_WIDTH,   63'h4000_0000_0000_0001, 1'b1,
      '{SH_NONE, 63'h2000_0000_0000_0000, 1'b1}}
  };

  logic clk;
  logic rst;

  // APB side
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [dmws_pkg::APB_ADDR_W-1:0] paddr;
  logic [dmws_pkg::APB_DATA_W-1:0] pwdata;
  logic [dmws_pkg::APB_DATA_W-1:0] prdata;
  logic                            pready;

  dmws_mask_if   win_if ();
  dmws_result_if res_if ();

  difference_multiplicity_window_step u_top (
    .clk     (clk),
    .rst     (rst),
    .window  (win_if),
    .result  (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Bench copy of the two registers.
  logic [dmws_pkg::CFG_W-1:0] width_cfg   = dmws_pkg::WIDTH_RESET;
  logic [dmws_pkg::CFG_W-1:0] repeats_cfg = dmws_pkg::REPEATS_RESET;

  window_result_t pending_windows [$];   // results owed by the block, oldest first
  int unsigned    mismatch_count = 0;
  bit             src_calm  = 1'b0;      // sender runs back to back
  bit             sink_calm = 1'b0;      // receiver never stalls

  // Append one owed result at the young end of the queue.
  function automatic void owe_result(input window_result_t want);
    pending_windows.insert(pending_windows.size(), want);
  endfunction

  // Window size actually in force: clamped into [MIN_WIDTH, MASK_W].
  function automatic int unsigned live_width(input logic [dmws_pkg::CFG_W-1:0] cfg);
    int unsigned w;
    w = cfg;
    if (w < dmws_pkg::MIN_WIDTH) w = dmws_pkg::MIN_WIDTH;
    if (w > dmws_pkg::MASK_W)    w = dmws_pkg::MASK_W;
    return w;
  endfunction

  // Successor windows and the pair-count verdict for one mask.
  function automatic window_result_t step_window(input logic [dmws_pkg::MASK_W-1:0] mask);
    window_result_t r;
    int unsigned    w;
    logic [63:0]    keep;
    logic [63:0]    sh;
    logic [63:0]    ext;
    w    = live_width(width_cfg);
    keep = (64'd1 << w) - 64'd1;
    sh   = ({1'b0, mask} & keep) >> 1;
    ext  = sh | (64'd1 << (w - 1));
    r.extend_ok = 1'b1;
    for (int unsigned d = 1; d < w; d++) begin
      if ($countones(ext & (ext >> d)) > repeats_cfg) r.extend_ok = 1'b0;
    end
    r.shifted_mask  = sh[dmws_pkg::SHIFT_W-1:0];
    r.extended_mask = ext[dmws_pkg::MASK_W-1:0];
    return r;
  endfunction

  // Random mask, biased so that both verdicts come up often: sparse picks,
  // arithmetic runs (which repeat one difference), dense noise, extremes.
  // Out-of-window bits are sprinkled in on top half the time.
  function automatic logic [dmws_pkg::MASK_W-1:0] draw_mask();
    logic [dmws_pkg::MASK_W-1:0] m;
    logic [63:0]                 keep;
    logic [63:0]                 rnd;
    int unsigned                 w;
    int unsigned                 kind;
    int unsigned                 pos;
    int unsigned                 stride;
    int unsigned                 cnt;
    w    = live_width(width_cfg);
    keep = (64'd1 << w) - 64'd1;
    kind = $urandom_range(0, 19);
    m    = '0;
    if (kind < 8) begin
      cnt = $urandom_range(0, 6);
      repeat (cnt) m[$urandom_range(0, w - 1)] = 1'b1;
    end else if (kind < 12) begin
      pos    = $urandom_range(0, w - 1);
      stride = $urandom_range(1, w - 1);
      cnt    = $urandom_range(2, 6);
      while (cnt > 0 && pos < w) begin
        m[pos] = 1'b1;
        pos += stride;
        cnt--;
      end
    end else if (kind < 18) begin
      rnd = {$urandom(), $urandom()};
      m   = rnd[dmws_pkg::MASK_W-1:0];
    end else if (kind == 18) begin
      m = '1;
    end
    if ($urandom_range(0, 1) == 1) begin
      rnd = {$urandom(), $urandom()};
      m |= rnd[dmws_pkg::MASK_W-1:0] & ~keep[dmws_pkg::MASK_W-1:0];
    end
    return m;
  endfunction

  // Stop feeding and let the pipe run dry.
  task automatic drain_pipe();
    win_if.valid <= 1'b0;
    while (pending_windows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write: setup then access; register takes the value on the access edge.
  task automatic write_reg(input dmws_pkg::reg_index_t sel,
                           input logic [dmws_pkg::CFG_W-1:0] val);
    drain_pipe();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= {{(dmws_pkg::APB_DATA_W-dmws_pkg::CFG_W){1'b0}}, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (sel == dmws_pkg::REG_WIDTH) width_cfg = val;
    else                            repeats_cfg = val;
  endtask

  // Present one mask after a random gap; returns at the accepting edge.
  // valid only drops when a gap is drawn, so back-to-back items keep it high.
  task automatic send_mask(input logic [dmws_pkg::MASK_W-1:0] mask,
                           input window_result_t want);
    int unsigned gap;
    gap = src_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      win_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    win_if.valid       <= 1'b1;
    win_if.window_mask <= mask;
    owe_result(want);
    do @(posedge clk); while (!win_if.ready);
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver: a fresh stall for every result item.
  initial begin : result_sink
    int unsigned stall;
    res_if.ready <= 1'b0;
    @(negedge rst);
    forever begin
      stall = sink_calm ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
    end
  end

  // Checker: each accepted result against the oldest expectation.
  always @(posedge clk) begin
    window_result_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (pending_windows.size() == 0) begin
        $display("%0t: unexpected result shifted=%h extended=%h ok=%b", $time,
                 res_if.shifted_mask, res_if.extended_mask, res_if.extend_ok);
        mismatch_count++;
      end else begin
        want = pending_windows.pop_front();
        if (res_if.shifted_mask !== want.shifted_mask) begin
          $display("%0t: shifted_mask expected %h actual %h", $time,
                   want.shifted_mask, res_if.shifted_mask);
          mismatch_count++;
        end
        if (res_if.extended_mask !== want.extended_mask) begin
          $display("%0t: extended_mask expected %h actual %h", $time,
                   want.extended_mask, res_if.extended_mask);
          mismatch_count++;
        end
        if (res_if.extend_ok !== want.extend_ok) begin
          $display("%0t: extend_ok expected %b actual %b", $time,
                   want.extend_ok, res_if.extend_ok);
          mismatch_count++;
        end
      end
    end
  end

  // Main sequence: reset, directed table, then randomized phases, each
  // under its own register settings.
  initial begin : stimulus
    logic [dmws_pkg::MASK_W-1:0] mask;
    logic [dmws_pkg::CFG_W-1:0]  w_set;
    logic [dmws_pkg::CFG_W-1:0]  g_set;
    logic [31:0]                 pick;
    stim_row_t                   row;

    rst                <= 1'b1;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    win_if.valid       <= 1'b0;
    win_if.window_mask <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: typed results where obvious, predictor for the rest.
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_CFG) begin
        write_reg(row.reg_sel, row.value[dmws_pkg::CFG_W-1:0]);
      end else begin
        send_mask(row.value, row.typed ? row.want : step_window(row.value));
      end
    end

    // Random phases. The first few pin the settings to edge values
    // (including out-of-range widths); later ones pick freely, mostly
    // with a small repeat limit so both verdicts stay common.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin w_set = dmws_pkg::WIDTH_RESET; g_set = dmws_pkg::REPEATS_RESET; end
        1: begin w_set = 6'd63; g_set = 6'd63; end
        2: begin w_set = 6'd3;  g_set = 6'd1;  end
        3: begin w_set = 6'd0;  g_set = 6'd0;  end
        4: begin w_set = 6'd63; g_set = 6'd0;  end
        5: begin w_set = 6'd8;  g_set = 6'd2;  end
        default: begin
          pick  = $urandom_range(0, 63);
          w_set = pick[dmws_pkg::CFG_W-1:0];
          pick  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                              : $urandom_range(0, 5);
          g_set = pick[dmws_pkg::CFG_W-1:0];
        end
      endcase
      write_reg(dmws_pkg::REG_WIDTH, w_set);
      write_reg(dmws_pkg::REG_REPEATS, g_set);
      src_calm  = (p % 4 == 1);
      sink_calm = (p % 3 == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // once, in the middle of a phase, hold off until the pipe is empty
        if (p == 7 && n == PHASE_ITEMS / 2) drain_pipe();
        mask = draw_mask();
        send_mask(mask, step_window(mask));
      end
    end

    drain_pipe();
    repeat (2 * DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_windows.size() == 0) begin
      $display("difference_multiplicity_window_step: match");
    end else begin
      $display("difference_multiplicity_window_step: mismatch");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #20ms;
    $display("difference_multiplicity_window_step: mismatch");
    $finish;
  end

endmodule

// ===== difference_multiplicity_window_step.f =====
design/dmws_pkg.sv
design/dmws_mask_if.sv
design/dmws_result_if.sv
design/dmws_diff_check.sv
design/difference_multiplicity_window_step.sv
sim/testbench.sv
